FILE: rtl/core/obj_face_index_parser_macros.svh
// assertion macros for the checker file of the face index parser
`ifndef OBJ_FACE_INDEX_PARSER_MACROS_SVH
`define OBJ_FACE_INDEX_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define OFIP_ASSERT_NOW(lbl, clk_sig, rst_n_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define OFIP_ASSERT_NEXT(lbl, clk_sig, rst_n_sig, ante, cons, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ofip_pkg.sv
// shared types and constants of the face index parser
`timescale 1ns / 1ps
`default_nettype none
package ofip_pkg;

	localparam int INDEX_BITS_DEF = 24;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TEXCOORD = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL   = 2'd2;

	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_V,
		PH_S1,
		PH_T,
		PH_S2,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic empty_face;
		logic last_of_face;
	} grp_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/obj_face_index_parser.sv
// top level of the face index parser: config registers, tokenizer and resolver
// Takes the characters of one face line (after the leading 'f') one word per cycle on
// s_tdata while s_tready is high, with s_tlast closing the line without a character,
// and returns one word per v[/vt][/vn] group with zero-based indices; the last group's
// word closes the line (tlast set); a line with no group gives one empty-face word. A
// result passes the group hand-off register and then the result register; these two
// register stages absorb back-pressure; s_tready drops only while both hold words that
// m_tready has not taken. Element counts come from the config channel and are read when
// a group is resolved; write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module obj_face_index_parser #(
	parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF,
	localparam int DATA_BITS = ((3 * INDEX_BITS + 7) / 8) * 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [7:0]                          s_tdata,   // character
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [DATA_BITS-1:0]                     m_tdata,   // position, texcoord, normal index
	output logic [3:0]                               m_tuser,   // has_texcoord, has_normal,
	                                                            // out_of_range, empty_face
	output logic                                     m_tlast,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ofip_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [INDEX_BITS-1:0]               cfg_data
);

	logic [INDEX_BITS-1:0] vertex_count_q, texcoord_count_q, normal_count_q;

	logic                  grp_valid, grp_ready;
	logic [INDEX_BITS+1:0] grp_pos, grp_tex, grp_nrm;
	ofip_pkg::grp_ctl_t    grp_ctl;

	logic [INDEX_BITS-1:0] position_index, texcoord_index, normal_index;
	logic                  has_texcoord, has_normal, out_of_range, empty_face;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q   <= '0;
			texcoord_count_q <= '0;
			normal_count_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ofip_pkg::CFG_VERTEX: begin
					vertex_count_q <= cfg_data;
				end
				ofip_pkg::CFG_TEXCOORD: begin
					texcoord_count_q <= cfg_data;
				end
				ofip_pkg::CFG_NORMAL: begin
					normal_count_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	ofip_tokenizer #(
		.INDEX_BITS(INDEX_BITS)
	) u_tokenizer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.ch         (s_tdata),
		.line_final (s_tlast),
		.grp_valid  (grp_valid),
		.grp_ready  (grp_ready),
		.grp_pos    (grp_pos),
		.grp_tex    (grp_tex),
		.grp_nrm    (grp_nrm),
		.grp_ctl    (grp_ctl)
	);

	ofip_resolver #(
		.INDEX_BITS(INDEX_BITS)
	) u_resolver (
		.clk            (clk),
		.arst_n         (arst_n),
		.grp_valid      (grp_valid),
		.grp_ready      (grp_ready),
		.grp_pos        (grp_pos),
		.grp_tex        (grp_tex),
		.grp_nrm        (grp_nrm),
		.grp_ctl        (grp_ctl),
		.vertex_count   (vertex_count_q),
		.texcoord_count (texcoord_count_q),
		.normal_count   (normal_count_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.position_index (position_index),
		.texcoord_index (texcoord_index),
		.normal_index   (normal_index),
		.has_texcoord   (has_texcoord),
		.has_normal     (has_normal),
		.out_of_range   (out_of_range),
		.empty_face     (empty_face),
		.last_of_face   (m_tlast)
	);

	assign m_tdata = DATA_BITS'({normal_index, texcoord_index, position_index});
	assign m_tuser = {empty_face, out_of_range, has_normal, has_texcoord};

endmodule
`default_nettype wire

FILE: rtl/core/ofip_tokenizer.sv
// character tokenizer: number accumulate, group phase and group hand-off register
`timescale 1ns / 1ps
`default_nettype none
module ofip_tokenizer #(
	parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            ch,
	input  wire logic                  line_final,
	output logic                       grp_valid,
	input  wire logic                  grp_ready,
	output logic [INDEX_BITS+1:0]      grp_pos,
	output logic [INDEX_BITS+1:0]      grp_tex,
	output logic [INDEX_BITS+1:0]      grp_nrm,
	output ofip_pkg::grp_ctl_t         grp_ctl
);

	localparam int MW = INDEX_BITS + 1;
	localparam int PW = INDEX_BITS + 2;
	localparam int WW = INDEX_BITS + 5;
	localparam logic [WW-1:0] MAG_CAP = WW'(1) << INDEX_BITS;

	ofip_pkg::phase_t   phase_q, phase_d;
	logic [MW-1:0]      accum_q, accum_d;
	logic               neg_q, neg_d;
	logic               active_q, active_d;
	logic [PW-1:0]      pos_q, pos_d, tex_q, tex_d, nrm_q, nrm_d;
	logic [PW-1:0]      pos_f, tex_f, nrm_f, fin_word;
	logic               grp_valid_s1;
	logic [PW-1:0]      pos_s1, tex_s1, nrm_s1;
	ofip_pkg::grp_ctl_t ctl_s1, ctl_d;

	logic               in_acc, emit;
	logic               is_close, is_digit, is_minus, is_slash, fin;
	logic [WW-1:0]      acc_wide;
	logic [MW-1:0]      acc_sat;

	assign in_ready  = !grp_valid_s1 || grp_ready;
	assign in_acc    = in_valid && in_ready;
	assign grp_valid = grp_valid_s1;
	assign grp_pos   = pos_s1;
	assign grp_tex   = tex_s1;
	assign grp_nrm   = nrm_s1;
	assign grp_ctl   = ctl_s1;

	assign is_close = line_final || (ch == ofip_pkg::CH_NEWLINE);
	assign is_digit = (ch >= ofip_pkg::CH_ZERO) && (ch <= ofip_pkg::CH_NINE);
	assign is_minus = (ch == ofip_pkg::CH_MINUS);
	assign is_slash = (ch == ofip_pkg::CH_SLASH);

	// accum * 10 + digit, saturating at 2^INDEX_BITS
	assign acc_wide = (WW'(accum_q) << 3) + (WW'(accum_q) << 1) + WW'(ch[3:0]);
	assign acc_sat  = (acc_wide > MAG_CAP) ? MAG_CAP[MW-1:0] : acc_wide[MW-1:0];

	// number in progress ends on anything but a digit
	assign fin      = active_q && (is_close || !is_digit);
	assign fin_word = {neg_q && (accum_q != '0), accum_q};
	assign pos_f    = (fin && phase_q == ofip_pkg::PH_V) ? fin_word : pos_q;
	assign tex_f    = (fin && phase_q == ofip_pkg::PH_T) ? fin_word : tex_q;
	assign nrm_f    = (fin && phase_q == ofip_pkg::PH_DONE) ? fin_word : nrm_q;

	always_comb begin
		phase_d  = phase_q;
		accum_d  = accum_q;
		neg_d    = neg_q;
		active_d = active_q;
		pos_d    = pos_f;
		tex_d    = tex_f;
		nrm_d    = nrm_f;
		emit     = 1'b0;
		ctl_d    = '0;
		if (fin) begin
			active_d = 1'b0;
			accum_d  = '0;
			neg_d    = 1'b0;
		end
		if (is_close) begin
			emit               = 1'b1;
			ctl_d.empty_face   = (phase_q == ofip_pkg::PH_IDLE);
			ctl_d.last_of_face = 1'b1;
			phase_d            = ofip_pkg::PH_IDLE;
			pos_d              = '0;
			tex_d              = '0;
			nrm_d              = '0;
		end else if (is_digit && active_q) begin
			accum_d = acc_sat;
		end else if (is_digit || is_minus) begin
			active_d = 1'b1;
			neg_d    = is_minus;
			accum_d  = is_minus ? '0 : MW'(ch[3:0]);
			case (phase_q)
				ofip_pkg::PH_S1: begin
					phase_d = ofip_pkg::PH_T;
				end
				ofip_pkg::PH_S2: begin
					phase_d = ofip_pkg::PH_DONE;
				end
				ofip_pkg::PH_V, ofip_pkg::PH_T, ofip_pkg::PH_DONE: begin
					emit    = 1'b1;
					phase_d = ofip_pkg::PH_V;
					pos_d   = '0;
					tex_d   = '0;
					nrm_d   = '0;
				end
				default: begin
					phase_d = ofip_pkg::PH_V;
				end
			endcase
		end else if (is_slash) begin
			case (phase_q)
				ofip_pkg::PH_V: begin
					phase_d = ofip_pkg::PH_S1;
				end
				ofip_pkg::PH_S1, ofip_pkg::PH_T: begin
					phase_d = ofip_pkg::PH_S2;
				end
				ofip_pkg::PH_S2, ofip_pkg::PH_DONE: begin
					phase_d = ofip_pkg::PH_DONE;
				end
				default: begin
					phase_d = ofip_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ofip_pkg::PH_IDLE;
			accum_q  <= '0;
			neg_q    <= 1'b0;
			active_q <= 1'b0;
			pos_q    <= '0;
			tex_q    <= '0;
			nrm_q    <= '0;
		end else if (in_acc) begin
			phase_q  <= phase_d;
			accum_q  <= accum_d;
			neg_q    <= neg_d;
			active_q <= active_d;
			pos_q    <= pos_d;
			tex_q    <= tex_d;
			nrm_q    <= nrm_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_s1 <= 1'b0;
		end else if (in_acc && emit) begin
			grp_valid_s1 <= 1'b1;
		end else if (grp_ready) begin
			grp_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			pos_s1 <= pos_f;
			tex_s1 <= tex_f;
			nrm_s1 <= nrm_f;
			ctl_s1 <= ctl_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ofip_resolver.sv
// index resolution against the element counts and result register
`timescale 1ns / 1ps
`default_nettype none
module ofip_resolver #(
	parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  grp_valid,
	output logic                       grp_ready,
	input  wire logic [INDEX_BITS+1:0] grp_pos,
	input  wire logic [INDEX_BITS+1:0] grp_tex,
	input  wire logic [INDEX_BITS+1:0] grp_nrm,
	input  wire ofip_pkg::grp_ctl_t    grp_ctl,
	input  wire logic [INDEX_BITS-1:0] vertex_count,
	input  wire logic [INDEX_BITS-1:0] texcoord_count,
	input  wire logic [INDEX_BITS-1:0] normal_count,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [INDEX_BITS-1:0]      position_index,
	output logic [INDEX_BITS-1:0]      texcoord_index,
	output logic [INDEX_BITS-1:0]      normal_index,
	output logic                       has_texcoord,
	output logic                       has_normal,
	output logic                       out_of_range,
	output logic                       empty_face,
	output logic                       last_of_face
);

	// returns {present, bad, index}
	function automatic logic [INDEX_BITS+1:0] resolve(
		input logic [INDEX_BITS+1:0] word,
		input logic [INDEX_BITS-1:0] count
	);
		logic [INDEX_BITS:0]   mag;
		logic [INDEX_BITS-1:0] idx;
		logic                  present;
		logic                  bad;
		mag     = word[INDEX_BITS:0];
		present = (mag != '0);
		bad     = present && (mag > {1'b0, count});
		if (!present || bad) begin
			idx = '0;
		end else if (word[INDEX_BITS+1]) begin
			idx = count - mag[INDEX_BITS-1:0];
		end else begin
			idx = mag[INDEX_BITS-1:0] - INDEX_BITS'(1);
		end
		return {present, bad, idx};
	endfunction

	logic [INDEX_BITS+1:0] rp, rt, rn;
	logic                  grp_acc;
	logic                  out_valid_q;
	logic [INDEX_BITS-1:0] pos_idx_q, tex_idx_q, nrm_idx_q;
	logic                  has_t_q, has_n_q, oor_q, empty_q, last_q;

	assign rp = resolve(grp_pos, vertex_count);
	assign rt = resolve(grp_tex, texcoord_count);
	assign rn = resolve(grp_nrm, normal_count);

	assign grp_ready = !out_valid_q || out_ready;
	assign grp_acc   = grp_valid && grp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (grp_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_acc) begin
			empty_q <= grp_ctl.empty_face;
			last_q  <= grp_ctl.last_of_face;
			if (grp_ctl.empty_face) begin
				pos_idx_q <= '0;
				tex_idx_q <= '0;
				nrm_idx_q <= '0;
				has_t_q   <= 1'b0;
				has_n_q   <= 1'b0;
				oor_q     <= 1'b0;
			end else begin
				pos_idx_q <= rp[INDEX_BITS-1:0];
				tex_idx_q <= rt[INDEX_BITS-1:0];
				nrm_idx_q <= rn[INDEX_BITS-1:0];
				has_t_q   <= rt[INDEX_BITS+1];
				has_n_q   <= rn[INDEX_BITS+1];
				// a missing position counts as out of range
				oor_q     <= !rp[INDEX_BITS+1] || rp[INDEX_BITS] || rt[INDEX_BITS]
					|| rn[INDEX_BITS];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign position_index = pos_idx_q;
	assign texcoord_index = tex_idx_q;
	assign normal_index   = nrm_idx_q;
	assign has_texcoord   = has_t_q;
	assign has_normal     = has_n_q;
	assign out_of_range   = oor_q;
	assign empty_face     = empty_q;
	assign last_of_face   = last_q;

endmodule
`default_nettype wire

FILE: rtl/core/ofip_checker.sv
// port-level checks of the face index parser and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "obj_face_index_parser_macros.svh"
module ofip_checker #(
	parameter int INDEX_BITS = ofip_pkg::INDEX_BITS_DEF,
	localparam int DATA_BITS = ((3 * INDEX_BITS + 7) / 8) * 8
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [DATA_BITS-1:0] m_tdata,
	input wire logic [3:0]           m_tuser,
	input wire logic                 m_tlast
);

	logic                 out_stall;
	logic [DATA_BITS+5:0] out_word;
	logic                 empty_word;
	logic                 empty_ok;
	logic                 absent_ok;

	assign out_stall  = m_tvalid && !m_tready;
	assign out_word   = {m_tvalid, m_tlast, m_tuser, m_tdata};
	assign empty_word = m_tvalid && m_tuser[3];
	assign empty_ok   = m_tlast && (m_tdata == '0) && (m_tuser[2:0] == 3'b000);
	assign absent_ok  = (m_tuser[0] || (m_tdata[2*INDEX_BITS-1:INDEX_BITS] == '0))
		&& (m_tuser[1] || (m_tdata[3*INDEX_BITS-1:2*INDEX_BITS] == '0));

	// held result word must not change
	`OFIP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, $stable(out_word), "held word changed")

	// input stalls only under output back-pressure
	`OFIP_ASSERT_NOW(a_stall_cause, clk, arst_n, !s_tready, out_stall, "input stall without cause")

	// empty face word closes the line and carries nothing else
	`OFIP_ASSERT_NOW(a_empty_face, clk, arst_n, empty_word, empty_ok, "malformed empty face word")

	// absent texcoord or normal reads as index zero
	`OFIP_ASSERT_NOW(a_absent_zero, clk, arst_n, m_tvalid, absent_ok, "absent index not zero")

endmodule

bind obj_face_index_parser ofip_checker #(.INDEX_BITS(INDEX_BITS)) u_ofip_checker (.*);
`default_nettype wire
